// ===== rtl/mlfc_pkg.sv =====
// package for the motion light fade controller
// types, constants and phase codes shared by all rtl files; no dependencies
`default_nettype none

package mlfc_pkg;

    localparam int LEVEL_BITS = 10;
    localparam int DUTY_W     = 8;
    localparam int HOLD_W     = 17;
    localparam int STEP_W     = 8;
    localparam int POLL_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0]     FULL_DUTY       = DUTY_W'(255);
    localparam logic [LEVEL_BITS-1:0] DARK_THR_RESET  = LEVEL_BITS'(250);
    localparam logic [POLL_W-1:0]     POLL_RESET      = POLL_W'(100);
    localparam logic [STEP_W-1:0]     STEP_RESET      = STEP_W'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS     = 2'd2;

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_UP   = 2'd1,
        PH_ON   = 2'd2,
        PH_DOWN = 2'd3
    } phase_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] dark_threshold;
        logic [POLL_W-1:0]     poll_ticks;
        logic [STEP_W-1:0]     step_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [DUTY_W-1:0] duty;
        logic [HOLD_W-1:0] hold;
        logic [STEP_W-1:0] step;
    } fade_state_t;

endpackage

`default_nettype wire

// ===== rtl/motion_light_fade_controller.sv =====
// top level of the motion light fade controller
// depends on mlfc_pkg, mlfc_cfg_regs and mlfc_step
//
// usage:
//   in channel: one item per 5 ms tick, fields motion and light_level,
//   taken at a clock edge with in_valid high and in_stall low.
//   out channel: one item per input item, fields pwm_duty, lamp_on and
//   phase_code, taken at a clock edge with out_valid high and out_stall low.
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   dark_threshold, 1 poll_ticks, 2 step_ticks, index 3 is ignored;
//   cfg_ready is always high, write only while the block is idle.
// throughput: one item per cycle while out_stall is low. The edge that takes an item
//   updates phase, duty and counters and loads the result into the output register
//   at that same edge, or into the skid register while the output register holds a
//   stalled result; a result in the output register can be taken from the next edge on.
// reset: phase off, duty and counters zero (first tick makes a motion
//   check), configuration registers at their reset values.
// stall: a skid register behind the output register takes one more item
//   while a result waits; in_stall rises once both entries are full.
`default_nettype none

module motion_light_fade_controller (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               motion,
    input  wire logic [mlfc_pkg::LEVEL_BITS-1:0]    light_level,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [mlfc_pkg::DUTY_W-1:0]             pwm_duty,
    output logic                                    lamp_on,
    output logic [1:0]                              phase_code,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mlfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mlfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef struct packed {
        logic [mlfc_pkg::DUTY_W-1:0] duty;
        logic                        lamp;
        logic [1:0]                  phase;
    } result_t;

    mlfc_pkg::cfg_t        cfg;
    mlfc_pkg::fade_state_t state_reg;
    mlfc_pkg::fade_state_t state_next;
    result_t               res_new;
    result_t               out_reg;
    result_t               skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  accept;
    logic                  out_free;

    mlfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mlfc_step u_step (
        .cfg         (cfg),
        .cur         (state_reg),
        .motion      (motion),
        .light_level (light_level),
        .nxt         (state_next)
    );

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid & ~skid_valid_reg;
    assign out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        res_new.duty  = state_next.duty;
        res_new.phase = state_next.phase;
        res_new.lamp  = state_next.phase inside {mlfc_pkg::PH_ON, mlfc_pkg::PH_DOWN};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= mlfc_pkg::PH_OFF;
            state_reg.duty  <= '0;
            state_reg.hold  <= '0;
            state_reg.step  <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res_new;
        end
        else if (accept)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pwm_duty   = out_reg.duty;
    assign lamp_on    = out_reg.lamp;
    assign phase_code = out_reg.phase;

endmodule

`default_nettype wire

// ===== rtl/mlfc_cfg_regs.sv =====
// configuration register file for the motion light fade controller
// depends on mlfc_pkg
`default_nettype none

module mlfc_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mlfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mlfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mlfc_pkg::cfg_t                          cfg
);

    mlfc_pkg::cfg_t cfg_reg;
    logic           wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold <= mlfc_pkg::DARK_THR_RESET;
            cfg_reg.poll_ticks     <= mlfc_pkg::POLL_RESET;
            cfg_reg.step_ticks     <= mlfc_pkg::STEP_RESET;
        end
        else if (wr)
        begin
            case (cfg_index)
                mlfc_pkg::REG_DARK_THRESHOLD:
                    cfg_reg.dark_threshold <= cfg_data[mlfc_pkg::LEVEL_BITS-1:0];
                mlfc_pkg::REG_POLL_TICKS:
                    cfg_reg.poll_ticks <= cfg_data[mlfc_pkg::POLL_W-1:0];
                mlfc_pkg::REG_STEP_TICKS:
                    cfg_reg.step_ticks <= cfg_data[mlfc_pkg::STEP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mlfc_step.sv =====
// next-state logic of the fade controller for one tick item
// depends on mlfc_pkg
`default_nettype none

module mlfc_step (
    input  wire mlfc_pkg::cfg_t                        cfg,
    input  wire mlfc_pkg::fade_state_t                 cur,
    input  wire logic                                  motion,
    input  wire logic [mlfc_pkg::LEVEL_BITS-1:0]       light_level,
    output mlfc_pkg::fade_state_t                      nxt
);

    logic [mlfc_pkg::HOLD_W-1:0] poll_len;
    logic [mlfc_pkg::HOLD_W-1:0] poll_hold;
    logic [mlfc_pkg::HOLD_W-1:0] dbl_hold;
    logic [mlfc_pkg::STEP_W-1:0] step_hold;
    logic [mlfc_pkg::DUTY_W-1:0] duty_inc;
    logic [mlfc_pkg::DUTY_W-1:0] duty_dec;
    logic                        dark;

    // zero lengths count as one
    assign poll_len  = (cfg.poll_ticks == '0) ? mlfc_pkg::HOLD_W'(1)
                                              : mlfc_pkg::HOLD_W'(cfg.poll_ticks);
    assign poll_hold = poll_len - mlfc_pkg::HOLD_W'(1);
    assign dbl_hold  = {poll_len[mlfc_pkg::HOLD_W-2:0], 1'b0} - mlfc_pkg::HOLD_W'(1);
    assign step_hold = (cfg.step_ticks == '0) ? '0
                                              : cfg.step_ticks - mlfc_pkg::STEP_W'(1);
    assign duty_inc  = cur.duty + mlfc_pkg::DUTY_W'(1);
    assign duty_dec  = (cur.duty == '0) ? '0 : cur.duty - mlfc_pkg::DUTY_W'(1);
    assign dark      = light_level < cfg.dark_threshold;

    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            mlfc_pkg::PH_OFF:
            begin
                if (cur.hold != '0)
                    nxt.hold = cur.hold - mlfc_pkg::HOLD_W'(1);
                else if (!motion)
                    nxt.hold = poll_hold;
                else if (!dark)
                    nxt.hold = dbl_hold;
                else if (cur.duty >= mlfc_pkg::FULL_DUTY)
                begin
                    nxt.duty  = mlfc_pkg::FULL_DUTY;
                    nxt.phase = mlfc_pkg::PH_ON;
                    nxt.hold  = poll_hold;
                end
                else
                begin
                    nxt.phase = mlfc_pkg::PH_UP;
                    nxt.step  = step_hold;
                end
            end
            mlfc_pkg::PH_UP:
            begin
                if (cur.step != '0)
                    nxt.step = cur.step - mlfc_pkg::STEP_W'(1);
                else if (duty_inc >= mlfc_pkg::FULL_DUTY)
                begin
                    nxt.duty  = mlfc_pkg::FULL_DUTY;
                    nxt.phase = mlfc_pkg::PH_ON;
                    nxt.hold  = poll_hold;
                end
                else
                begin
                    nxt.duty = duty_inc;
                    nxt.step = step_hold;
                end
            end
            mlfc_pkg::PH_ON:
            begin
                if (cur.hold != '0)
                    nxt.hold = cur.hold - mlfc_pkg::HOLD_W'(1);
                else if (motion)
                    nxt.hold = poll_hold;
                else if (cur.duty == '0)
                begin
                    nxt.phase = mlfc_pkg::PH_OFF;
                    nxt.hold  = poll_hold;
                end
                else
                begin
                    nxt.phase = mlfc_pkg::PH_DOWN;
                    nxt.step  = step_hold;
                end
            end
            default:
            begin
                if (cur.step != '0)
                    nxt.step = cur.step - mlfc_pkg::STEP_W'(1);
                else if (motion)
                begin
                    // motion during ramp-down snaps back to full
                    nxt.duty  = mlfc_pkg::FULL_DUTY;
                    nxt.phase = mlfc_pkg::PH_ON;
                    nxt.hold  = poll_hold;
                end
                else if (duty_dec == '0)
                begin
                    nxt.duty  = '0;
                    nxt.phase = mlfc_pkg::PH_OFF;
                    nxt.hold  = poll_hold;
                end
                else
                begin
                    nxt.duty = duty_dec;
                    nxt.step = step_hold;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== test/tb_motion_light_fade_controller.sv =====
`timescale 1ns / 1ps
// testbench for motion_light_fade_controller: tick driver, output stall pattern
// and a scoreboard class that predicts the phase and duty of every item
// depends on mlfc_pkg and the rtl of the block

typedef struct {
    logic [mlfc_pkg::DUTY_W-1:0] duty;
    logic                        lamp;
    mlfc_pkg::phase_t            phase;
} lamp_out_t;

class fade_tracker;
    logic [mlfc_pkg::LEVEL_BITS-1:0] dark_thr;
    logic [mlfc_pkg::POLL_W-1:0]     poll;
    logic [mlfc_pkg::STEP_W-1:0]     step;
    mlfc_pkg::phase_t                ph;
    int unsigned                     duty;
    int unsigned                     hold;
    int unsigned                     step_left;
    lamp_out_t                       expected_outputs[$];
    int                              errors;
    int                              checked;
    int                              ticks;

    function new();
        dark_thr  = mlfc_pkg::DARK_THR_RESET;
        poll      = mlfc_pkg::POLL_RESET;
        step      = mlfc_pkg::STEP_RESET;
        ph        = mlfc_pkg::PH_OFF;
        duty      = 0;
        hold      = 0;
        step_left = 0;
        errors    = 0;
        checked   = 0;
        ticks     = 0;
    endfunction

    function void write_reg(logic [mlfc_pkg::CFG_IDX_W-1:0] idx,
                            logic [mlfc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mlfc_pkg::REG_DARK_THRESHOLD: dark_thr = data[mlfc_pkg::LEVEL_BITS-1:0];
            mlfc_pkg::REG_POLL_TICKS:     poll     = data[mlfc_pkg::POLL_W-1:0];
            mlfc_pkg::REG_STEP_TICKS:     step     = data[mlfc_pkg::STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // a zero length counts as one tick
    function int unsigned poll_len();
        return (poll == 0) ? 1 : int'(poll);
    endfunction

    function int unsigned step_len();
        return (step == 0) ? 1 : int'(step);
    endfunction

    function void settle_on();
        duty = int'(mlfc_pkg::FULL_DUTY);
        ph   = mlfc_pkg::PH_ON;
        hold = poll_len() - 1;
    endfunction

    function void settle_off();
        duty = 0;
        ph   = mlfc_pkg::PH_OFF;
        hold = poll_len() - 1;
    endfunction

    function void take_tick(logic mot, logic [mlfc_pkg::LEVEL_BITS-1:0] lvl);
        logic      dark;
        lamp_out_t r;
        dark = (lvl < dark_thr);
        ticks++;
        case (ph)
            mlfc_pkg::PH_OFF:
            begin
                if (hold != 0)
                    hold--;
                else if (!mot)
                    hold = poll_len() - 1;
                else if (!dark)
                    hold = 2 * poll_len() - 1;
                else if (duty >= int'(mlfc_pkg::FULL_DUTY))
                    settle_on();
                else
                begin
                    ph        = mlfc_pkg::PH_UP;
                    step_left = step_len() - 1;
                end
            end
            mlfc_pkg::PH_UP:
            begin
                if (step_left != 0)
                    step_left--;
                else
                begin
                    duty++;
                    if (duty >= int'(mlfc_pkg::FULL_DUTY))
                        settle_on();
                    else
                        step_left = step_len() - 1;
                end
            end
            mlfc_pkg::PH_ON:
            begin
                if (hold != 0)
                    hold--;
                else if (mot)
                    hold = poll_len() - 1;
                else if (duty == 0)
                    settle_off();
                else
                begin
                    ph        = mlfc_pkg::PH_DOWN;
                    step_left = step_len() - 1;
                end
            end
            default:
            begin
                if (step_left != 0)
                    step_left--;
                else if (mot)
                    settle_on();   // motion during the fade snaps back to full
                else
                begin
                    if (duty != 0)
                        duty--;
                    if (duty == 0)
                        settle_off();
                    else
                        step_left = step_len() - 1;
                end
            end
        endcase
        r.duty  = mlfc_pkg::DUTY_W'(duty);
        r.lamp  = (ph == mlfc_pkg::PH_ON || ph == mlfc_pkg::PH_DOWN);
        r.phase = ph;
        expected_outputs.push_back(r);
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task match_output(logic [mlfc_pkg::DUTY_W-1:0] d, logic lamp, logic [1:0] code);
        lamp_out_t want;
        if (expected_outputs.size() == 0)
            report($sformatf("output item with no tick pending (duty %0d phase %0d)", d, code));
        else
        begin
            want = expected_outputs.pop_front();
            checked++;
            if (d !== want.duty)
                report($sformatf("pwm_duty %0d, expected %0d", d, want.duty));
            if (lamp !== want.lamp)
                report($sformatf("lamp_on %0b, expected %0b", lamp, want.lamp));
            if (code !== want.phase)
                report($sformatf("phase_code %0d, expected %0d", code, want.phase));
        end
    endtask
endclass

module tb_motion_light_fade_controller;

    localparam int CYCLE_LIMIT = 300000;
    localparam logic [mlfc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int NUM_SEGS = 7;

    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                in_valid    = 1'b0;
    wire                                 in_stall;
    logic                                motion      = 1'b0;
    logic [mlfc_pkg::LEVEL_BITS-1:0]     light_level = '0;
    wire                                 out_valid;
    logic                                out_stall   = 1'b0;
    wire  [mlfc_pkg::DUTY_W-1:0]         pwm_duty;
    wire                                 lamp_on;
    wire  [1:0]                          phase_code;
    logic                                cfg_valid   = 1'b0;
    wire                                 cfg_ready;
    logic [mlfc_pkg::CFG_IDX_W-1:0]      cfg_index   = '0;
    logic [mlfc_pkg::CFG_DATA_W-1:0]     cfg_data    = '0;

    fade_tracker tracker = new();

    int          stall_mode = 0;
    int          stall_run  = 0;
    logic        stall_hi   = 1'b0;
    bit          idling_on  = 1'b0;
    int          burst_left = 0;
    int          cur_dark   = 250;
    int          settings   = 1;
    int unsigned cycles     = 0;

    int seg_dark[NUM_SEGS]    = '{1023, 250, 0, 600, 512, 1023, 300};
    int seg_poll[NUM_SEGS]    = '{1, 1, 0, 4, 65535, 2, 1};
    int seg_step[NUM_SEGS]    = '{1, 2, 0, 1, 255, 1, 1};
    int seg_items[NUM_SEGS]   = '{300, 120, 40, 220, 30, 260, 80};
    int seg_on_max[NUM_SEGS]  = '{60, 40, 10, 30, 8, 20, 15};
    int seg_off_max[NUM_SEGS] = '{30, 20, 10, 60, 8, 300, 15};

    motion_light_fade_controller u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .motion      (motion),
        .light_level (light_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pwm_duty    (pwm_duty),
        .lamp_on     (lamp_on),
        .phase_code  (phase_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver side stall pattern
    always @(posedge clk)
    begin
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 99) < 35);
            2:
            begin
                if (stall_run == 0)
                begin
                    stall_hi  = !stall_hi;
                    stall_run = $urandom_range(1, 12);
                end
                stall_run--;
                out_stall <= stall_hi;
            end
            default: out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.match_output(pwm_duty, lamp_on, phase_code);
            if (in_valid && !in_stall)
                tracker.take_tick(motion, light_level);
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    task automatic send_tick(input logic m, input logic [mlfc_pkg::LEVEL_BITS-1:0] lvl);
        int gap;
        if (idling_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid    <= 1'b1;
        motion      <= m;
        light_level <= lvl;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (tracker.expected_outputs.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg_port(input logic [mlfc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mlfc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // upper data bits beyond each register width are random
    task automatic apply_setting(input int dark, input int poll, input int step, input bit spare);
        logic [mlfc_pkg::CFG_DATA_W-1:0] data;
        wait_drained();
        data = mlfc_pkg::CFG_DATA_W'($urandom);
        data[mlfc_pkg::LEVEL_BITS-1:0] = mlfc_pkg::LEVEL_BITS'(dark);
        write_reg_port(mlfc_pkg::REG_DARK_THRESHOLD, data);
        write_reg_port(mlfc_pkg::REG_POLL_TICKS, mlfc_pkg::CFG_DATA_W'(poll));
        data = mlfc_pkg::CFG_DATA_W'($urandom);
        data[mlfc_pkg::STEP_W-1:0] = mlfc_pkg::STEP_W'(step);
        write_reg_port(mlfc_pkg::REG_STEP_TICKS, data);
        if (spare)
            write_reg_port(REG_SPARE, mlfc_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_dark = dark;
        settings++;
    endtask

    function automatic logic [mlfc_pkg::LEVEL_BITS-1:0] pick_light(input int thr);
        int pick;
        int v;
        pick = int'($urandom_range(0, 99));
        if (pick < 25)
            v = thr + int'($urandom_range(0, 4)) - 2;
        else if (pick < 35)
            v = 0;
        else if (pick < 45)
            v = 1023;
        else
            v = int'($urandom_range(0, 1023));
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return mlfc_pkg::LEVEL_BITS'(v);
    endfunction

    initial
    begin
        int   s;
        int   n;
        int   run_left;
        logic mot_level;
        logic m;
        run_left  = 0;
        mot_level = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first tick checks at once, light just under the threshold
        send_tick(1'b1, 10'd249);
        send_tick(1'b0, 10'd0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b0, 10'd1023);
        send_tick(1'b1, 10'd0);
        send_tick(1'b0, 10'd512);
        send_tick(1'b1, 10'd511);

        for (s = 0; s < NUM_SEGS; s++)
        begin
            apply_setting(seg_dark[s], seg_poll[s], seg_step[s], s == 2);
            idling_on  = (s % 3) != 0;
            stall_mode = (s + 1) % 3;
            for (n = 0; n < seg_items[s]; n++)
            begin
                if (run_left == 0)
                begin
                    mot_level = !mot_level;
                    run_left  = mot_level ? $urandom_range(1, seg_on_max[s])
                                          : $urandom_range(1, seg_off_max[s]);
                end
                run_left--;
                m = mot_level;
                if ($urandom_range(0, 99) < 3)
                    m = !m;   // sensor glitch
                send_tick(m, pick_light(cur_dark));
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("%0d ticks driven under %0d register settings, %0d output items compared",
                 tracker.ticks, settings, tracker.checked);
        if (tracker.errors == 0 && tracker.expected_outputs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
